### src/qdws_pkg.sv
// Shared constants, codes and types of the quadrature decoder with speed.
`default_nettype none

package qdws_pkg;

  // Widths of the position counter and of the edge timer.
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned TIME_WIDTH  = 32;

  // Widths of the word fields on the ports.
  localparam int unsigned STAMP_WIDTH = 32;
  localparam int unsigned OUT_WIDTH   = 32;

  // Speed limit, which is also the dividend of the speed divide.
  localparam int unsigned  DIVIDEND_WIDTH = 32;
  localparam logic [DIVIDEND_WIDTH-1:0] SPEED_LIMIT = 32'h7FFF_FFFF;

  // Input function codes.
  localparam logic [1:0] FUNC_EDGE_A = 2'd0;
  localparam logic [1:0] FUNC_EDGE_B = 2'd1;
  localparam logic [1:0] FUNC_ZERO   = 2'd2;
  localparam logic [1:0] FUNC_SYNC   = 2'd3;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // What the back part has to do with a word.
  typedef enum logic [1:0] {
    JOB_EDGE,
    JOB_ZERO,
    JOB_SYNC
  } job_kind_e;

  // One word from the front part to the back part.
  typedef struct packed {
    job_kind_e              kind;
    logic                   forward;
    logic [TIME_WIDTH-1:0]  elapsed;
    logic [OUT_WIDTH-1:0]   position;
    logic [1:0]             phase;
  } job_t;

endpackage

`default_nettype wire

### src/quadrature_decoder_with_speed.sv
// Top level of the x4 quadrature decoder with period-based speed.
// A zero-position or synchronize word, or an edge with no elapsed time, needs no divide; an edge
// with elapsed time gives its result once the one-bit-per-cycle speed divider is done. Non-edge
// words can stream at one per cycle while results are popped; an edge with elapsed time holds off
// later words until its divide is done. A two-entry job queue parts the front part from the divider.
// Reset clears phase, position, edge time, speed and all queues at once; no clearing pass.
`default_nettype none

module quadrature_decoder_with_speed (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [1:0]                        func_i,
  input  wire logic [qdws_pkg::STAMP_WIDTH-1:0]  timestamp_i,
  input  wire logic [1:0]                        levels_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic signed [qdws_pkg::OUT_WIDTH-1:0]  position_o,
  output logic signed [qdws_pkg::OUT_WIDTH-1:0]  speed_o,
  output logic [1:0]                             phase_o
);

  qdws_pkg::job_t  push_job, head_job;
  logic            q_push, q_full, q_pop, q_empty;

  // Event decoding and state tracking.
  qdws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .func_i      (func_i),
    .timestamp_i (timestamp_i),
    .levels_i    (levels_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  // Job queue.
  qdws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (head_job)
  );

  // Speed divide and result word.
  qdws_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_job_i    (head_job),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .position_o (position_o),
    .speed_o    (speed_o),
    .phase_o    (phase_o)
  );

endmodule

`default_nettype wire

### src/qdws_front.sv
// Front part: accepts events, tracks phase, position and edge time, and issues jobs.
`default_nettype none

module qdws_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push_i,
  output logic                                    full_o,
  input  wire logic [1:0]                         func_i,
  input  wire logic [qdws_pkg::STAMP_WIDTH-1:0]   timestamp_i,
  input  wire logic [1:0]                         levels_i,
  input  wire logic                               q_full_i,
  output logic                                    q_push_o,
  output qdws_pkg::job_t                          q_job_o
);

  logic [1:0]                         phase_q, phase_d;
  logic [qdws_pkg::COUNT_WIDTH-1:0]   pos_q, pos_d;
  logic [qdws_pkg::TIME_WIDTH-1:0]    time_q, time_d;
  logic [qdws_pkg::TIME_WIDTH-1:0]    stamp;
  logic                               forward;
  qdws_pkg::job_kind_e                kind;
  logic                               accept;

  // Sign-extends or truncates the counter to the width of the position port.
  function automatic logic [qdws_pkg::OUT_WIDTH-1:0] to_out(
    input logic [qdws_pkg::COUNT_WIDTH-1:0] p
  );
    return qdws_pkg::OUT_WIDTH'(signed'(p));
  endfunction

  assign full_o   = q_full_i;
  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;
  assign stamp    = qdws_pkg::TIME_WIDTH'(timestamp_i);

  // Decode the event and work out the next phase, position and edge time.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    time_d  = time_q;
    forward = 1'b0;
    kind    = qdws_pkg::JOB_ZERO;
    case (func_i)
      qdws_pkg::FUNC_EDGE_A: begin
        phase_d = phase_q ^ 2'b10;
        forward = phase_d[1] != phase_d[0];
        pos_d   = forward ? pos_q + 1'b1 : pos_q - 1'b1;
        time_d  = stamp;
        kind    = qdws_pkg::JOB_EDGE;
      end
      qdws_pkg::FUNC_EDGE_B: begin
        phase_d = phase_q ^ 2'b01;
        forward = phase_d[1] == phase_d[0];
        pos_d   = forward ? pos_q + 1'b1 : pos_q - 1'b1;
        time_d  = stamp;
        kind    = qdws_pkg::JOB_EDGE;
      end
      qdws_pkg::FUNC_ZERO: begin
        pos_d = '0;
        kind  = qdws_pkg::JOB_ZERO;
      end
      qdws_pkg::FUNC_SYNC: begin
        phase_d = levels_i;
        pos_d   = '0;
        time_d  = stamp;
        kind    = qdws_pkg::JOB_SYNC;
      end
      default: begin
        kind = qdws_pkg::JOB_ZERO;
      end
    endcase
  end

  // The job word carries the state after the event and the elapsed ticks.
  always_comb begin
    q_job_o.kind     = kind;
    q_job_o.forward  = forward;
    q_job_o.elapsed  = time_q - stamp;
    q_job_o.position = to_out(pos_d);
    q_job_o.phase    = phase_d;
  end

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      pos_q   <= '0;
      time_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      time_q  <= time_d;
    end
  end

endmodule

`default_nettype wire

### src/qdws_queue.sv
// Short queue of job words between the front and back parts.
`default_nettype none

module qdws_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  qdws_pkg::job_t       job_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output qdws_pkg::job_t       job_o
);

  localparam int unsigned PTR_W = $clog2(qdws_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(qdws_pkg::QUEUE_DEPTH + 1);

  qdws_pkg::job_t     entry_q [qdws_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  // Advances a pointer with wrap-around at the queue depth.
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(qdws_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = count_q == CNT_W'(qdws_pkg::QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = entry_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/qdws_back.sv
// Back part: carries out jobs, runs the speed divide and holds the result word.
`default_nettype none

module qdws_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              q_empty_i,
  input  qdws_pkg::job_t                         q_job_i,
  output logic                                   q_pop_o,
  input  wire logic                              pop_i,
  output logic                                   empty_o,
  output logic signed [qdws_pkg::OUT_WIDTH-1:0]  position_o,
  output logic signed [qdws_pkg::OUT_WIDTH-1:0]  speed_o,
  output logic [1:0]                             phase_o
);

  localparam int unsigned DW    = qdws_pkg::DIVIDEND_WIDTH;
  localparam int unsigned TW    = qdws_pkg::TIME_WIDTH;
  localparam int unsigned CNT_W = $clog2(DW);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  state_e                          state_q;
  logic                            out_valid_q;
  logic [qdws_pkg::OUT_WIDTH-1:0]  out_pos_q, hold_pos_q;
  logic [qdws_pkg::OUT_WIDTH-1:0]  out_speed_q, speed_q;
  logic [1:0]                      out_phase_q, hold_phase_q;
  logic                            hold_fwd_q;
  logic [TW-1:0]                   div_q, rem_q, rem_d;
  logic [DW-1:0]                   quo_q, quo_d;
  logic [CNT_W-1:0]                cnt_q;
  logic [TW:0]                     trial;
  logic                            take;
  logic                            out_load;

  // Applies the step direction to the speed magnitude.
  function automatic logic [qdws_pkg::OUT_WIDTH-1:0] signed_speed(
    input logic [DW-1:0] mag,
    input logic          fwd
  );
    logic [qdws_pkg::OUT_WIDTH-1:0] m;
    m = qdws_pkg::OUT_WIDTH'(mag);
    return fwd ? m : '0 - m;
  endfunction

  // A job is taken when idle and the result register is free or being emptied.
  assign take    = (state_q == ST_IDLE) && !q_empty_i && (!out_valid_q || pop_i);
  assign q_pop_o = take;

  // The result register is loaded by a job that needs no divide or by the last divide step.
  assign out_load = (take && !(q_job_i.kind == qdws_pkg::JOB_EDGE && q_job_i.elapsed != '0))
                 || (state_q == ST_DIV && cnt_q == CNT_W'(DW - 1));

  // One restoring divide step: one quotient bit per cycle.
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = TW'(trial - {1'b0, div_q});
      quo_d = {quo_q[DW-2:0], 1'b1};
    end else begin
      rem_d = trial[TW-1:0];
      quo_d = {quo_q[DW-2:0], 1'b0};
    end
  end

  assign empty_o    = !out_valid_q;
  assign position_o = out_pos_q;
  assign speed_o    = out_speed_q;
  assign phase_o    = out_phase_q;

  // Sequencer, divider registers, speed state and the result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      speed_q      <= '0;
      cnt_q        <= '0;
      out_pos_q    <= '0;
      out_speed_q  <= '0;
      out_phase_q  <= '0;
      hold_pos_q   <= '0;
      hold_phase_q <= '0;
      hold_fwd_q   <= 1'b0;
      div_q        <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            case (q_job_i.kind)
              qdws_pkg::JOB_EDGE: begin
                if (q_job_i.elapsed == '0) begin
                  // No time since the last edge: the speed saturates.
                  speed_q     <= signed_speed(qdws_pkg::SPEED_LIMIT, q_job_i.forward);
                  out_speed_q <= signed_speed(qdws_pkg::SPEED_LIMIT, q_job_i.forward);
                  out_pos_q   <= q_job_i.position;
                  out_phase_q <= q_job_i.phase;
                end else begin
                  hold_pos_q   <= q_job_i.position;
                  hold_phase_q <= q_job_i.phase;
                  hold_fwd_q   <= q_job_i.forward;
                  div_q        <= q_job_i.elapsed;
                  rem_q        <= '0;
                  quo_q        <= qdws_pkg::SPEED_LIMIT;
                  cnt_q        <= '0;
                  state_q      <= ST_DIV;
                end
              end
              qdws_pkg::JOB_SYNC: begin
                speed_q     <= '0;
                out_speed_q <= '0;
                out_pos_q   <= q_job_i.position;
                out_phase_q <= q_job_i.phase;
              end
              default: begin
                // Zero position keeps the last speed.
                out_speed_q <= speed_q;
                out_pos_q   <= q_job_i.position;
                out_phase_q <= q_job_i.phase;
              end
            endcase
          end
        end
        ST_DIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DW - 1)) begin
            speed_q     <= signed_speed(quo_d, hold_fwd_q);
            out_speed_q <= signed_speed(quo_d, hold_fwd_q);
            out_pos_q   <= hold_pos_q;
            out_phase_q <= hold_phase_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench of the x4 quadrature decoder with period-based speed.
`timescale 1ns / 100ps

// One expected result word: the decoder state after an event.
typedef struct {
  logic [31:0] position;
  logic [31:0] speed;
  logic [1:0]  phase;
} reading_t;

// Tracks the decoder state and holds the readings still owed by the block.
class decoder_scoreboard;
  logic [1:0]  phase     = 2'b00;
  logic [31:0] position  = '0;
  logic [31:0] last_time = '0;
  logic [31:0] speed     = '0;
  reading_t    pending_readings[$];
  int          mismatch_count = 0;

  // Apply one accepted event to the tracked state and queue the reading it gives.
  function void note_event(logic [1:0] func, logic [31:0] stamp, logic [1:0] levels);
    logic [31:0] elapsed;
    logic [31:0] magnitude;
    logic        forward;
    reading_t    reading;
    case (func)
      qdws_pkg::FUNC_EDGE_A, qdws_pkg::FUNC_EDGE_B: begin
        if (func == qdws_pkg::FUNC_EDGE_A) begin
          phase[1] = ~phase[1];
          forward  = (phase[1] != phase[0]);
        end else begin
          phase[0] = ~phase[0];
          forward  = (phase[1] == phase[0]);
        end
        // The timer counts down, so elapsed ticks are old minus new.
        elapsed   = last_time - stamp;
        magnitude = (elapsed == 32'd0) ? qdws_pkg::SPEED_LIMIT
                                       : qdws_pkg::SPEED_LIMIT / elapsed;
        position  = forward ? position + 32'd1 : position - 32'd1;
        speed     = forward ? magnitude : 32'd0 - magnitude;
        last_time = stamp;
      end
      qdws_pkg::FUNC_ZERO: begin
        position = '0;
      end
      default: begin
        phase     = levels;
        position  = '0;
        speed     = '0;
        last_time = stamp;
      end
    endcase
    reading.position = position;
    reading.speed    = speed;
    reading.phase    = phase;
    pending_readings.push_back(reading);
  endfunction

  // Compare one popped word with the oldest reading owed.
  function void check_reading(logic [31:0] position_seen, logic [31:0] speed_seen,
                              logic [1:0] phase_seen);
    reading_t owed;
    if (pending_readings.size() == 0) begin
      $display("%0t: word popped with none expected: position %0d speed %0d phase %0d",
               $time, $signed(position_seen), $signed(speed_seen), phase_seen);
      mismatch_count++;
      return;
    end
    owed = pending_readings.pop_front();
    if (position_seen !== owed.position) begin
      $display("%0t: position expected %0d actual %0d", $time, $signed(owed.position),
               $signed(position_seen));
      mismatch_count++;
    end
    if (speed_seen !== owed.speed) begin
      $display("%0t: speed expected %0d actual %0d", $time, $signed(owed.speed),
               $signed(speed_seen));
      mismatch_count++;
    end
    if (phase_seen !== owed.phase) begin
      $display("%0t: phase expected %0d actual %0d", $time, owed.phase, phase_seen);
      mismatch_count++;
    end
  endfunction
endclass

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 600_000;

  logic                                  clk_i = 1'b0;
  logic                                  rst_ni;
  logic                                  push;
  logic                                  full;
  logic [1:0]                            func_i;
  logic [qdws_pkg::STAMP_WIDTH-1:0]      timestamp_i;
  logic [1:0]                            levels_i;
  logic                                  empty;
  logic                                  pop;
  logic signed [qdws_pkg::OUT_WIDTH-1:0] position_o;
  logic signed [qdws_pkg::OUT_WIDTH-1:0] speed_o;
  logic [1:0]                            phase_o;

  decoder_scoreboard sb = new();

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  bit          run_forward    = 1'b1;

  quadrature_decoder_with_speed u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .timestamp_i (timestamp_i),
    .levels_i    (levels_i),
    .empty       (empty),
    .pop         (pop),
    .position_o  (position_o),
    .speed_o     (speed_o),
    .phase_o     (phase_o)
  );

  // Clock with a 10 ns period.
  always #5 clk_i = ~clk_i;

  // Cycle counter that ends a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Result side: pop at random, check every word taken.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      pop = rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_reading(position_o, speed_o, phase_o);
    end
  end

  // Offer one word, idling first for a random number of cycles, and wait until it is taken.
  task automatic send_word(input logic [1:0] func, input logic [31:0] stamp,
                           input logic [1:0] levels);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      push = 1'b0;
    end
    @(negedge clk_i);
    push        = 1'b1;
    func_i      = func;
    timestamp_i = stamp;
    levels_i    = levels;
    do @(posedge clk_i); while (full);
    sb.note_event(func, stamp, levels);
  endtask

  // Send the edge that steps the encoder one count in the given direction.
  task automatic send_step(input bit forward, input logic [31:0] delta);
    logic [1:0] func;
    bit         a_is_next;
    // Forward order is 00, 10, 11, 01: channel A moves from 00 and 11.
    a_is_next = (sb.phase == 2'b00) || (sb.phase == 2'b11);
    func = (a_is_next == forward) ? qdws_pkg::FUNC_EDGE_A : qdws_pkg::FUNC_EDGE_B;
    send_word(func, sb.last_time - delta, 2'($urandom_range(0, 3)));
  endtask

  // Hold the sender off until every owed reading has been popped.
  task automatic drain_readings();
    @(negedge clk_i);
    push = 1'b0;
    while (sb.pending_readings.size() != 0) @(posedge clk_i);
  endtask

  // One random word: mostly coherent rotation, some commands and some noise.
  task automatic send_random_word();
    int          pick;
    logic [31:0] delta;
    pick = $urandom_range(0, 99);
    if (pick < 82) begin
      if ($urandom_range(0, 7) == 0) begin
        run_forward = ~run_forward;
      end
      case ($urandom_range(0, 9))
        0:       delta = 32'($urandom_range(0, 2));
        1:       delta = $urandom;
        2:       delta = 32'($urandom_range(0, 32'h7FFF_FFFF));
        default: delta = 32'($urandom_range(1, 5000));
      endcase
      send_step(run_forward, delta);
    end else if (pick < 88) begin
      send_word(qdws_pkg::FUNC_ZERO, $urandom, 2'($urandom_range(0, 3)));
    end else if (pick < 94) begin
      send_word(qdws_pkg::FUNC_SYNC, $urandom, 2'($urandom_range(0, 3)));
    end else begin
      send_word(2'($urandom_range(0, 3)), $urandom, 2'($urandom_range(0, 3)));
    end
  endtask

  // Main sequence: reset, directed words, then random phases of idling.
  initial begin
    push        = 1'b0;
    func_i      = qdws_pkg::FUNC_EDGE_A;
    timestamp_i = '0;
    levels_i    = 2'b00;
    rst_ni      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Synchronise with every level pair; A high alone maps to phase A.
    send_word(qdws_pkg::FUNC_SYNC, 32'h0000_0000, 2'b10);
    send_word(qdws_pkg::FUNC_SYNC, 32'hFFFF_FFFF, 2'b01);
    send_word(qdws_pkg::FUNC_SYNC, 32'h8000_0000, 2'b11);
    send_word(qdws_pkg::FUNC_SYNC, 32'h0000_0000, 2'b00);
    // Zero elapsed time saturates, in both directions, with short times between.
    send_step(1'b1, 32'd0);
    send_step(1'b1, 32'd1);
    send_step(1'b0, 32'd2);
    send_step(1'b0, 32'd0);
    // Elapsed times past the limit give a zero speed; then the limit and a short time.
    send_step(1'b0, 32'hFFFF_FFFF);
    send_step(1'b1, 32'h8000_0000);
    send_step(1'b1, 32'h7FFF_FFFF);
    send_step(1'b1, 32'd3);
    // Zero position keeps phase, speed and time.
    send_word(qdws_pkg::FUNC_ZERO, 32'h1234_5678, 2'b11);
    // Step below zero so the position wraps negative.
    send_step(1'b0, 32'd7);
    send_step(1'b0, 32'd1000);
    send_step(1'b0, 32'd1);
    send_word(qdws_pkg::FUNC_ZERO, 32'hFFFF_FFFF, 2'b00);
    send_word(qdws_pkg::FUNC_SYNC, 32'h5555_5555, 2'b11);
    send_step(1'b1, 32'd3);
    send_step(1'b1, 32'd100);
    send_step(1'b0, 32'd0);
    send_word(qdws_pkg::FUNC_EDGE_A, 32'hAAAA_AAAA, 2'b01);
    send_word(qdws_pkg::FUNC_EDGE_B, 32'h0000_0001, 2'b10);
    drain_readings();

    // Random words under each idling pattern, draining in between.
    for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
      case (phase_idx)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      repeat (300) send_random_word();
      drain_readings();
    end

    // Allow the divider latency to pass for any stray word.
    repeat (40) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending_readings.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
src/qdws_pkg.sv
src/qdws_front.sv
src/qdws_queue.sv
src/qdws_back.sv
src/quadrature_decoder_with_speed.sv
verif/tb_top.sv
